// ----- hw/rtl/irpd_pkg.sv -----
package irpd_pkg;

	// Register file geometry
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int TIME_W  = 32;
	localparam int CODE_W  = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX   = 3'd5;

	// Register reset values, microseconds
	localparam logic [CFG_W-1:0] SHORT_MIN_RST  = 16'd450;
	localparam logic [CFG_W-1:0] SHORT_MAX_RST  = 16'd650;
	localparam logic [CFG_W-1:0] MEDIUM_MIN_RST = 16'd1500;
	localparam logic [CFG_W-1:0] MEDIUM_MAX_RST = 16'd1700;
	localparam logic [CFG_W-1:0] LONG_MIN_RST   = 16'd4400;
	localparam logic [CFG_W-1:0] LONG_MAX_RST   = 16'd4600;

	// Item commands
	localparam logic CMD_EDGE  = 1'b0;
	localparam logic CMD_REARM = 1'b1;

	// Window bounds, all exclusive
	typedef struct packed {
		logic [CFG_W-1:0] short_min;
		logic [CFG_W-1:0] short_max;
		logic [CFG_W-1:0] medium_min;
		logic [CFG_W-1:0] medium_max;
		logic [CFG_W-1:0] long_min;
		logic [CFG_W-1:0] long_max;
	} cfg_t;

endpackage

// ----- hw/rtl/irpd_if.sv -----
interface irpd_item_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [irpd_pkg::TIME_W-1:0]   edge_time;

	modport source (output valid, output cmd, output edge_time, input ready);
	modport sink (input valid, input cmd, input edge_time, output ready);
endinterface

interface irpd_result_if;
	logic                          valid;
	logic                          ready;
	logic                          frame_ready;
	logic [irpd_pkg::CODE_W-1:0]   code;

	modport source (output valid, output frame_ready, output code, input ready);
	modport sink (input valid, input frame_ready, input code, output ready);
endinterface

// ----- hw/rtl/irpd_cfg_regs.sv -----
module irpd_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [irpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [irpd_pkg::CFG_W-1:0]       cfg_data,
	output irpd_pkg::cfg_t                   cfg
);

	irpd_pkg::cfg_t cfg_q;

	// Write the addressed window bound; drop writes past the last register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_min  <= irpd_pkg::SHORT_MIN_RST;
			cfg_q.short_max  <= irpd_pkg::SHORT_MAX_RST;
			cfg_q.medium_min <= irpd_pkg::MEDIUM_MIN_RST;
			cfg_q.medium_max <= irpd_pkg::MEDIUM_MAX_RST;
			cfg_q.long_min   <= irpd_pkg::LONG_MIN_RST;
			cfg_q.long_max   <= irpd_pkg::LONG_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				irpd_pkg::REG_SHORT_MIN:  cfg_q.short_min  <= cfg_data;
				irpd_pkg::REG_SHORT_MAX:  cfg_q.short_max  <= cfg_data;
				irpd_pkg::REG_MEDIUM_MIN: cfg_q.medium_min <= cfg_data;
				irpd_pkg::REG_MEDIUM_MAX: cfg_q.medium_max <= cfg_data;
				irpd_pkg::REG_LONG_MIN:   cfg_q.long_min   <= cfg_data;
				irpd_pkg::REG_LONG_MAX:   cfg_q.long_max   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/irpd_decode.sv -----
module irpd_decode #(
	parameter int FRAME_BITS       = 32,
	parameter int LEADER_INTERVALS = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          cmd,
	input  logic [irpd_pkg::TIME_W-1:0]   edge_time,
	input  irpd_pkg::cfg_t                cfg,
	output logic                          frame_ready,
	output logic [irpd_pkg::CODE_W-1:0]   code
);

	localparam int TOTAL = LEADER_INTERVALS + 2 * FRAME_BITS;
	localparam int CNT_W = $clog2(TOTAL + 1);
	localparam int BIT_W = $clog2(FRAME_BITS);
	localparam logic [CNT_W-1:0] TOTAL_C = CNT_W'(TOTAL);
	localparam logic [CNT_W-1:0] LEAD_C  = CNT_W'(LEADER_INTERVALS);
	localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(FRAME_BITS - 1);

	logic [CNT_W-1:0]            count_q, count_d, data_idx;
	logic [irpd_pkg::TIME_W-1:0] prev_q, prev_d, delta;
	logic [FRAME_BITS-1:0]       shift_q, shift_d;
	logic [BIT_W-1:0]            bit_pos;
	logic                        is_short, is_medium, is_long;

	// Classify the interval since the last edge against the windows
	assign delta     = edge_time - prev_q;
	assign is_short  = (delta > 32'(cfg.short_min)) && (delta < 32'(cfg.short_max));
	assign is_medium = (delta > 32'(cfg.medium_min)) && (delta < 32'(cfg.medium_max));
	assign is_long   = (delta > 32'(cfg.long_min)) && (delta < 32'(cfg.long_max));

	// Data intervals count from zero after the leader; bits land MSB first
	assign data_idx = count_q - LEAD_C;
	assign bit_pos  = TOP_BIT - data_idx[BIT_W:1];

	// Advance the frame tracker by one item
	always_comb begin
		count_d = count_q;
		prev_d  = prev_q;
		shift_d = shift_q;
		if (cmd == irpd_pkg::CMD_REARM) begin
			count_d = '0;
		end else if (count_q < TOTAL_C) begin
			prev_d = edge_time;
			if (count_q < LEAD_C) begin
				count_d = is_long ? count_q + CNT_W'(1) : '0;
			end else if (!data_idx[0]) begin
				count_d = is_short ? count_q + CNT_W'(1) : '0;
			end else if (is_short) begin
				shift_d[bit_pos] = 1'b0;
				count_d          = count_q + CNT_W'(1);
			end else if (is_medium) begin
				shift_d[bit_pos] = 1'b1;
				count_d          = count_q + CNT_W'(1);
			end else begin
				count_d = '0;
			end
		end
	end

	// Hold tracker state between items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			prev_q  <= '0;
			shift_q <= '0;
		end else if (step) begin
			count_q <= count_d;
			prev_q  <= prev_d;
			shift_q <= shift_d;
		end
	end

	// Report the frame as it stands after this item
	assign frame_ready = (count_d >= TOTAL_C);
	assign code        = frame_ready ? irpd_pkg::CODE_W'(shift_d) : '0;

endmodule

// ----- hw/rtl/ir_pulse_distance_decoder_top.sv -----
// Infrared pulse-distance frame decoder. Each beat on item carries an edge
// timestamp (cmd edge) or a rearm request (cmd rearm); each produces exactly
// one beat on result with frame_ready and the decoded code (zero until the
// frame is complete). One item is taken every clock cycle while the result
// side keeps taking beats. An accepted item sits in the input register; as it
// advances it passes through the window compare and frame tracker into the
// result register, and result valid rises as it lands there. The tracker
// state is updated only as an item moves into the result register, so a
// stalled result simply holds the input register, and the input side keeps
// taking beats while the input register is free.
// Window bounds must be written through the cfg port by the user only while
// no item is in flight; the block itself does not enforce this.
module ir_pulse_distance_decoder_top #(
	parameter int FRAME_BITS       = 32,
	parameter int LEADER_INTERVALS = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [irpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [irpd_pkg::CFG_W-1:0]       cfg_data,
	irpd_item_if.sink                        item,
	irpd_result_if.source                    result
);

	irpd_pkg::cfg_t              cfg;
	logic                        item_valid_s1;
	logic                        cmd_s1;
	logic [irpd_pkg::TIME_W-1:0] edge_time_s1;
	logic                        res_valid_s2;
	logic                        frame_ready_s2;
	logic [irpd_pkg::CODE_W-1:0] code_s2;
	logic                        advance;
	logic                        dec_ready;
	logic [irpd_pkg::CODE_W-1:0] dec_code;

	irpd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Move the held item on when the result register is free or being drained
	assign advance    = item_valid_s1 && (!res_valid_s2 || result.ready);
	assign item.ready = !item_valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item.ready) begin
			item_valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1       <= item.cmd;
			edge_time_s1 <= item.edge_time;
		end
	end

	irpd_decode #(
		.FRAME_BITS       (FRAME_BITS),
		.LEADER_INTERVALS (LEADER_INTERVALS)
	) u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.cmd         (cmd_s1),
		.edge_time   (edge_time_s1),
		.cfg         (cfg),
		.frame_ready (dec_ready),
		.code        (dec_code)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (result.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_ready_s2 <= dec_ready;
			code_s2        <= dec_code;
		end
	end

	assign result.valid       = res_valid_s2;
	assign result.frame_ready = frame_ready_s2;
	assign result.code        = code_s2;

	// A frame that is not ready always reports a zero code
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.frame_ready) |-> (result.code == '0))
		else $error("nonzero code without frame_ready");

	// A rearm always yields a not-ready result
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cmd_s1 == irpd_pkg::CMD_REARM) |=> (result.valid && !result.frame_ready))
		else $error("rearm produced a ready frame");

	// A held item stays put until it moves into the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid_s1 && !advance) |=> (item_valid_s1 && $stable(edge_time_s1)
			&& $stable(cmd_s1)))
		else $error("input register lost a stalled item");

endmodule
